// ===== src/dit_pkg.sv =====
`default_nettype none

package dit_pkg;

   localparam int MAX_INTERVALS = 32;
   localparam int VALUE_WIDTH   = 32;

   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int IDX_W = $clog2(MAX_INTERVALS);

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      value_type lo;
      value_type hi;
   } entry_type;

   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
      entry_type           data;
   } wr_type;

   // shared compare unit results
   typedef struct packed {
      logic nxt_le_v;   // next entry start <= value
      logic prv_ge_v;   // previous entry end >= value
      logic prv_is_vm1; // previous entry end == value - 1
      logic nxt_is_vp1; // next entry start == value + 1
   } cmp_type;

   // low VALUE_WIDTH bits of the request field, as two's complement
   function automatic value_type from_in(input logic signed [31:0] x);
      logic signed [63:0] w;
      w = 64'(x);
      return w[VALUE_WIDTH-1:0];
   endfunction

   // stored bound sign extended, then cut to the 32-bit result field
   function automatic logic [31:0] to_out(input value_type x);
      logic signed [63:0] w;
      w = 64'(x);
      return w[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/disjoint_interval_tracker.sv =====
`default_nettype none

// disjoint interval tracker
// keeps an ascending table of up to MAX_INTERVALS disjoint closed intervals
// in a single-port-write, single-port-read memory driven by a small sequencer.
// request channel (req_*): opcode add (value joins the set) or read (dump).
// response channel (rsp_*): one beat per add, one beat per stored interval
// on a read (rsp_last_item marks the final one), one empty-flagged beat on a
// read of an empty table. an add that needs a new entry in a full table is
// dropped and answered with status full.
// add: the sequencer fetches and compares each entry scanned (entries with
// start <= value, plus one); on a merge or insert it reads and writes each
// entry shifted and then leaves the shift loop; an insert then writes the
// new entry; last, the result beat is loaded. read: each interval is read
// from memory, then loaded as an output beat; an empty table gives one beat.
// throughput: one item at a time; req_ready is high only while the sequencer
// sits idle, and the scan and shift loops over the memory keep it busy.
// a result sits in the output register, so a new request is taken while the
// receiver stalls; the sequencer only waits when it must load a further beat.
// reset (synchronous) empties the table at once by clearing the fill count;
// no clearing pass is made over the memory.
module disjoint_interval_tracker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_opcode,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_range_low,
   output logic signed [31:0]      rsp_range_high,
   output logic                    rsp_last_item,
   output logic [1:0]              rsp_status
);
   import dit_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN_RD  = 9'b000000010,  // fetch candidate entry
      S_SCAN_CHK = 9'b000000100,  // compare and decide
      S_MV_RD    = 9'b000001000,  // fetch entry to shift
      S_MV_WR    = 9'b000010000,  // write shifted entry
      S_INS      = 9'b000100000,  // write new single-value interval
      S_DONE     = 9'b001000000,  // post add / empty result
      S_RD_ADDR  = 9'b010000000,  // readout fetch
      S_RD_OUT   = 9'b100000000   // readout beat
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;   // intervals held
   logic [CNT_W-1:0]  idx_ff, idx_in;       // scan position, ends as insert point
   logic [CNT_W-1:0]  i_ff, i_in;           // shift / readout position
   logic              up_ff, up_in;         // shift direction: up closes a gap
   logic              have_prev_ff, have_prev_in;
   entry_type         prev_ff, prev_in;     // last entry with start <= value
   value_type         v_ff, v_in;
   logic [1:0]        status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_lo_ff, rsp_lo_in;
   logic [31:0]       rsp_hi_ff, rsp_hi_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   wr_type            wr;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         rd_data;
   cmp_type           flags;

   logic              out_free;
   logic              nxt_ok;
   logic              join_low;
   logic              join_high;
   logic [CNT_W-1:0]  idx_m1;
   logic [CNT_W-1:0]  i_up;
   logic [CNT_W-1:0]  i_dn;
   logic [CNT_W-1:0]  src;

   dit_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one compare unit, reused for every scanned entry
   dit_cmp u_cmp (
      .value  (v_ff),
      .prv_hi (prev_ff.hi),
      .nxt_lo (rd_data.lo),
      .flags  (flags)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign nxt_ok    = (idx_ff < count_ff);
   assign join_low  = have_prev_ff && flags.prv_is_vm1;
   assign join_high = nxt_ok && flags.nxt_is_vp1;
   assign idx_m1    = idx_ff - CNT_W'(1);
   assign i_up      = i_ff + CNT_W'(1);
   assign i_dn      = i_ff - CNT_W'(1);
   assign src       = up_ff ? i_up : i_dn;

   always_comb begin
      unique case (state_ff)
         S_SCAN_RD:            rd_addr = idx_ff[IDX_W-1:0];
         S_MV_RD:              rd_addr = src[IDX_W-1:0];
         S_RD_ADDR, S_RD_OUT:  rd_addr = i_ff[IDX_W-1:0];
         default:              rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      i_in          = i_ff;
      up_in         = up_ff;
      have_prev_in  = have_prev_ff;
      prev_in       = prev_ff;
      v_in          = v_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      wr            = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               v_in = from_in(req_value);
               if (req_opcode == OP_READ) begin
                  i_in = '0;
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_RD_ADDR;
                  end
               end else begin
                  idx_in       = '0;
                  have_prev_in = 1'b0;
                  state_in     = S_SCAN_RD;
               end
            end
         end

         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end

         S_SCAN_CHK: begin
            status_in = ST_OK;
            priority if (nxt_ok && flags.nxt_le_v) begin
               // entry start still at or below the value: step on
               prev_in      = rd_data;
               have_prev_in = 1'b1;
               idx_in       = idx_ff + CNT_W'(1);
               state_in     = S_SCAN_RD;
            end else if (have_prev_ff && flags.prv_ge_v) begin
               state_in = S_DONE;
            end else if (join_low && join_high) begin
               // merge: lower entry takes the upper end, then close the gap
               wr.en      = 1'b1;
               wr.addr    = idx_m1[IDX_W-1:0];
               wr.data.lo = prev_ff.lo;
               wr.data.hi = rd_data.hi;
               count_in   = count_ff - CNT_W'(1);
               i_in       = idx_ff;
               up_in      = 1'b1;
               state_in   = S_MV_RD;
            end else if (join_low) begin
               wr.en      = 1'b1;
               wr.addr    = idx_m1[IDX_W-1:0];
               wr.data.lo = prev_ff.lo;
               wr.data.hi = v_ff;
               state_in   = S_DONE;
            end else if (join_high) begin
               wr.en      = 1'b1;
               wr.addr    = idx_ff[IDX_W-1:0];
               wr.data.lo = v_ff;
               wr.data.hi = rd_data.hi;
               state_in   = S_DONE;
            end else if (count_ff == CNT_W'(MAX_INTERVALS)) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               // open a slot at the insert point, moving entries from the top
               i_in     = count_ff;
               up_in    = 1'b0;
               state_in = S_MV_RD;
            end
         end

         S_MV_RD: begin
            priority if (up_ff ? (i_ff < count_ff) : (i_ff > idx_ff)) begin
               state_in = S_MV_WR;
            end else if (up_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_INS;
            end
         end

         S_MV_WR: begin
            wr.en    = 1'b1;
            wr.addr  = i_ff[IDX_W-1:0];
            wr.data  = rd_data;
            i_in     = up_ff ? i_up : i_dn;
            state_in = S_MV_RD;
         end

         S_INS: begin
            wr.en      = 1'b1;
            wr.addr    = idx_ff[IDX_W-1:0];
            wr.data.lo = v_ff;
            wr.data.hi = v_ff;
            count_in   = count_ff + CNT_W'(1);
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_lo_in     = '0;
               rsp_hi_in     = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         S_RD_ADDR: begin
            state_in = S_RD_OUT;
         end

         S_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_lo_in     = to_out(rd_data.lo);
               rsp_hi_in     = to_out(rd_data.hi);
               rsp_last_in   = (i_up == count_ff);
               rsp_status_in = ST_OK;
               i_in          = i_up;
               state_in      = (i_up == count_ff) ? S_IDLE : S_RD_ADDR;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      i_ff          <= i_in;
      up_ff         <= up_in;
      have_prev_ff  <= have_prev_in;
      prev_ff       <= prev_in;
      v_ff          <= v_in;
      status_ff     <= status_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_range_low  = rsp_lo_ff;
   assign rsp_range_high = rsp_hi_ff;
   assign rsp_last_item  = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

   // fill count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_INTERVALS))
      else $error("interval count above table depth");

   // the table is only written while an add is being worked
   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff != S_IDLE && state_ff != S_RD_ADDR && state_ff != S_RD_OUT))
      else $error("table write outside add sequence");

   // scan index never passes the fill count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CHK) |-> (idx_ff <= count_ff))
      else $error("scan index past fill count");

   // readout only addresses filled entries
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_ADDR || state_ff == S_RD_OUT) |-> (i_ff < count_ff))
      else $error("readout index past fill count");

   // a beat loaded while the receiver stalls would overwrite a pending one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_lo_ff)
                                        && $stable(rsp_status_ff)))
      else $error("pending response beat overwritten");

endmodule

`default_nettype wire

// ===== src/dit_table.sv =====
`default_nettype none

module dit_table (
   input  wire logic                    clock,
   input  wire dit_pkg::wr_type         wr,
   input  wire logic [dit_pkg::IDX_W-1:0] rd_addr,
   output dit_pkg::entry_type           rd_data
);
   import dit_pkg::*;

   entry_type mem [MAX_INTERVALS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/dit_cmp.sv =====
`default_nettype none

module dit_cmp (
   input  wire dit_pkg::value_type value,
   input  wire dit_pkg::value_type prv_hi,
   input  wire dit_pkg::value_type nxt_lo,
   output dit_pkg::cmp_type        flags
);
   import dit_pkg::*;

   // one guard bit so value +/- 1 never wraps
   logic signed [VALUE_WIDTH:0] v_x;
   logic signed [VALUE_WIDTH:0] a_x;
   logic signed [VALUE_WIDTH:0] b_x;
   logic signed [VALUE_WIDTH:0] vm1;
   logic signed [VALUE_WIDTH:0] vp1;

   assign v_x = {value[VALUE_WIDTH-1], value};
   assign a_x = {prv_hi[VALUE_WIDTH-1], prv_hi};
   assign b_x = {nxt_lo[VALUE_WIDTH-1], nxt_lo};
   assign vm1 = v_x - (VALUE_WIDTH+1)'(1);
   assign vp1 = v_x + (VALUE_WIDTH+1)'(1);

   always_comb begin
      flags.nxt_le_v   = (b_x <= v_x);
      flags.prv_ge_v   = (a_x >= v_x);
      flags.prv_is_vm1 = (a_x == vm1);
      flags.nxt_is_vp1 = (b_x == vp1);
   end

endmodule

`default_nettype wire
